### hdl/cda_pkg.sv
// Package for the calendar date adder: kind codes, result struct, month lengths.
// Used by cda_mod400, cda_core and calendar_date_adder_unit.
package cda_pkg;

  localparam int unsigned MAX_YEAR_DEF = 9999;

  // Field widths fixed by the beat format
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned AMT_W   = 16;
  localparam int unsigned CNT_W   = AMT_W - 1;
  localparam int unsigned REM_W   = 9;

  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;
  localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;

  typedef enum logic [1:0] {
    K_DAYS      = 2'd0,
    K_MONTHS    = 2'd1,
    K_YEARS     = 2'd2,
    K_YEARS_ONE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               ovf;
  } res_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_st_t;

  // Gregorian leap rule from the low year bits and the year mod 400
  function automatic logic is_leap(input logic [1:0] y_lo, input logic [REM_W-1:0] r400);
    logic century;
    century = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
    return (y_lo == 2'd0) && !century;
  endfunction

  // Days in a month; months outside 1..12 read as 31
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [DAY_W-1:0] clamp_day(input logic [DAY_W-1:0] d,
                                                 input logic [DAY_W-1:0] len);
    return (d > len) ? len : d;
  endfunction

endpackage

### hdl/cda_mod400.sv
// Remainder unit: year mod 400 by reciprocal multiplication.
// Depends on cda_pkg.
module cda_mod400 import cda_pkg::*; #(
  parameter int unsigned YW = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [YW-1:0]        value,
  output logic                 done,
  output logic [REM_W-1:0]     rem
);

  // Working width covers every year up to 16 bits
  localparam int unsigned VW     = 16;
  // v / 400 = (v / 16) / 25; 5243 / 2^17 gives exact quotients by 25 below 2^12
  localparam int unsigned RCP_W  = 13;
  localparam int unsigned RCP_SH = 17;
  localparam int unsigned PW     = VW - 4 + RCP_W;
  localparam int unsigned QW     = PW - RCP_SH;
  localparam logic [RCP_W-1:0] RCP_25 = 13'd5243;
  localparam logic [VW-1:0]    DIV    = 16'd400;

  logic [VW-1:0]    val_r, val_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic             ld_r, quo_vld_r, done_r;
  logic [PW-1:0]    prod;
  logic [VW-1:0]    diff;

  // Quotient from the upper bits, then the remainder by one subtract
  assign prod = PW'(val_r[VW-1:4]) * PW'(RCP_25);
  assign diff = val_r - VW'(quo_r) * DIV;

  always_comb begin
    val_nxt = start ? VW'(value) : val_r;
    quo_nxt = ld_r ? prod[PW-1:RCP_SH] : quo_r;
    rem_nxt = quo_vld_r ? diff[REM_W-1:0] : rem_r;
  end

  // Advance the value through quotient and remainder stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r      <= 1'b0;
      quo_vld_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      ld_r      <= start;
      quo_vld_r <= ld_r;
      done_r    <= quo_vld_r;
    end
    val_r <= val_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### hdl/cda_core.sv
// Sequencer and date registers: normalizes the start date and steps it one unit a cycle.
// Add years at once adds the count in one sum. Depends on cda_pkg and cda_mod400.
module cda_core import cda_pkg::*; #(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         kind,
  input  logic [DAY_W-1:0]   start_day,
  input  logic [MONTH_W-1:0] start_month,
  input  logic [YEAR_W-1:0]  start_year,
  input  logic [AMT_W-1:0]   amount,
  input  logic               res_ready,
  output core_st_t           st,
  output res_t               res
);

  localparam int unsigned YW = $clog2(MAX_YEAR + 1);
  localparam int unsigned IW = (YW > YEAR_W) ? YW : YEAR_W;
  localparam int unsigned SW = ((YW > CNT_W) ? YW : CNT_W) + 1;
  localparam logic [YW-1:0] MAXY = YW'(MAX_YEAR);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RED   = 6'b000010,
    S_CLAMP = 6'b000100,
    S_ADDY  = 6'b001000,
    S_STEP  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  kind_t              kind_r, kind_nxt;
  logic [DAY_W-1:0]   d_r, d_nxt;
  logic [MONTH_W-1:0] m_r, m_nxt;
  logic [YW-1:0]      y_r, y_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [REM_W-1:0]   r400_r, r400_nxt;
  logic               ovf_r, ovf_nxt;
  logic               add_done_r, add_done_nxt;

  logic [IW-1:0]      y_in_w, y_cl, y_out_w;
  logic [YW-1:0]      y_norm, y_add, y_inc, red_val;
  logic [SW-1:0]      y_sum;
  logic [MONTH_W-1:0] m_norm, m_inc;
  logic [DAY_W-1:0]   d_norm;
  logic [REM_W-1:0]   r_inc, red_rem;
  logic               leap_cur, leap_nx, at_max, add_ovf, red_start, red_done;

  // Normalize the incoming date fields
  assign y_in_w = IW'(start_year);
  assign y_cl   = (y_in_w == '0) ? IW'(1) :
                  (y_in_w > IW'(MAX_YEAR)) ? IW'(MAX_YEAR) : y_in_w;
  assign y_norm = y_cl[YW-1:0];
  assign m_norm = (start_month == '0) ? JANUARY :
                  (start_month > DECEMBER) ? DECEMBER : start_month;
  assign d_norm = (start_day == '0) ? DAY_W'(1) : start_day;

  // Leap flags for the current and the following year
  assign y_inc    = y_r + 1'b1;
  assign m_inc    = m_r + 1'b1;
  assign r_inc    = (r400_r == 9'd399) ? '0 : r400_r + 1'b1;
  assign leap_cur = is_leap(y_r[1:0], r400_r);
  assign leap_nx  = is_leap(y_inc[1:0], r_inc);
  assign at_max   = y_r >= MAXY;

  // Year added at once, held at the maximum
  assign y_sum   = SW'(y_r) + SW'(n_r);
  assign add_ovf = y_sum > SW'(MAX_YEAR);
  assign y_add   = add_ovf ? MAXY : y_sum[YW-1:0];

  // Shared remainder unit, started on accept and with an at-once add
  assign red_start = start || (state_r == S_ADDY);
  assign red_val   = (state_r == S_ADDY) ? y_add : y_norm;

  cda_mod400 #(.YW(YW)) u_mod400 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (red_start),
    .value (red_val),
    .done  (red_done),
    .rem   (red_rem)
  );

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    d_nxt        = d_r;
    m_nxt        = m_r;
    y_nxt        = y_r;
    n_nxt        = n_r;
    cnt_nxt      = cnt_r;
    r400_nxt     = r400_r;
    ovf_nxt      = ovf_r;
    add_done_nxt = add_done_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt     = kind_t'(kind);
          d_nxt        = d_norm;
          m_nxt        = m_norm;
          y_nxt        = y_norm;
          n_nxt        = amount[AMT_W-1] ? '0 : amount[CNT_W-1:0];
          cnt_nxt      = '0;
          ovf_nxt      = 1'b0;
          add_done_nxt = 1'b0;
          state_nxt    = S_RED;
        end
      end
      S_RED: begin
        if (red_done) begin
          r400_nxt  = red_rem;
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        d_nxt = clamp_day(d_r, month_len(m_r, leap_cur));
        if (kind_r == K_YEARS_ONE) begin
          state_nxt = (add_done_r || (n_r == '0)) ? S_DONE : S_ADDY;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_ADDY: begin
        y_nxt        = y_add;
        ovf_nxt      = add_ovf;
        add_done_nxt = 1'b1;
        state_nxt    = S_RED;
      end
      S_STEP: begin
        if (cnt_r == n_r) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          case (kind_r)
            K_DAYS: begin
              if (d_r < month_len(m_r, leap_cur)) begin
                d_nxt = d_r + 1'b1;
              end else if (m_r < DECEMBER) begin
                d_nxt = DAY_W'(1);
                m_nxt = m_inc;
              end else if (at_max) begin
                ovf_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else begin
                d_nxt    = DAY_W'(1);
                m_nxt    = JANUARY;
                y_nxt    = y_inc;
                r400_nxt = r_inc;
              end
            end
            K_MONTHS: begin
              if (m_r < DECEMBER) begin
                m_nxt = m_inc;
                d_nxt = clamp_day(d_r, month_len(m_inc, leap_cur));
              end else if (at_max) begin
                ovf_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else begin
                // January always has 31 days, so the day stays
                m_nxt    = JANUARY;
                y_nxt    = y_inc;
                r400_nxt = r_inc;
              end
            end
            K_YEARS: begin
              if (at_max) begin
                ovf_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else begin
                y_nxt    = y_inc;
                r400_nxt = r_inc;
                d_nxt    = clamp_day(d_r, month_len(m_r, leap_nx));
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    kind_r     <= kind_nxt;
    d_r        <= d_nxt;
    m_r        <= m_nxt;
    y_r        <= y_nxt;
    n_r        <= n_nxt;
    cnt_r      <= cnt_nxt;
    r400_r     <= r400_nxt;
    ovf_r      <= ovf_nxt;
    add_done_r <= add_done_nxt;
  end

  // Present the finished date
  assign y_out_w      = IW'(y_r);
  assign st.idle      = (state_r == S_IDLE);
  assign st.res_valid = (state_r == S_DONE);
  assign res.day      = d_r;
  assign res.month    = m_r;
  assign res.year     = y_out_w[YEAR_W-1:0];
  assign res.ovf      = ovf_r;

endmodule

### hdl/calendar_date_adder_unit.sv
// Top level of the calendar date adder: stream ports, output register, checks.
// Depends on cda_pkg and cda_core.
//
// Usage: one input beat carries a start date, a signed count and a kind in
// in_tuser (add days, add months stepwise, add years stepwise, add years at
// once). Each input beat produces exactly one output beat with the end date;
// out_tuser flags that the year would have passed MAX_YEAR.
// The stepping kinds (n = positive count) step one day, month or year per
// cycle, up to n times; add years at once adds the count in one sum. The
// mod-400 remainder unit runs once on accept and, for add years at once with
// a positive count, once more on the sum.
// One item is in work at a time: in_tready is high only while the sequencer is
// idle, so a new beat is taken only after the last result leaves the sequencer.
// The result sits in an output register; a new item is accepted while it
// waits to be taken. A stalled receiver holds the sequencer once it has a
// second result ready.
// Reset (rst_n low, synchronous) empties the sequencer and the output register.
module calendar_date_adder_unit import cda_pkg::*; #(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [4:0] start_day, [8:5] start_month, [22:9] start_year, [38:23] amount
  input  logic [39:0] in_tdata,
  // [1:0] kind
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] end_day, [8:5] end_month, [22:9] end_year
  output logic [23:0] out_tdata,
  // [0] overflow
  output logic        out_tuser
);

  core_st_t st;
  res_t     res;
  res_t     out_r, out_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     res_ready, in_beat;

  assign in_tready = st.idle;
  assign in_beat   = in_tvalid && in_tready;
  assign res_ready = !out_valid_r || out_tready;

  cda_core #(.MAX_YEAR(MAX_YEAR)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_beat),
    .kind        (in_tuser),
    .start_day   (in_tdata[4:0]),
    .start_month (in_tdata[8:5]),
    .start_year  (in_tdata[22:9]),
    .amount      (in_tdata[38:23]),
    .res_ready   (res_ready),
    .st          (st),
    .res         (res)
  );

  // Load the output register when it is empty or being drained
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (st.res_valid && res_ready) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.year, out_r.month, out_r.day};
  assign out_tuser  = out_r.ovf;

  // An accepted beat keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_tready)
    else $error("input accepted again while an item is in work");

  // Overflow leaves the year at the maximum
  a_ovf_year: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[22:9] == YEAR_W'(MAX_YEAR))
    else $error("overflow result without maximum year");

  // Result month stays within the calendar
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8:5] != 4'd0) && (out_tdata[8:5] <= DECEMBER))
    else $error("result month out of range");

  // Result day is never zero
  a_day_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:0] != 5'd0)
    else $error("result day is zero");

endmodule
